FILE: rtl/core/mts_pkg.sv
package mts_pkg;

    // Stack geometry
    localparam int DEPTH      = 64;
    localparam int DATA_WIDTH = 32;
    localparam int ADDR_W     = $clog2(DEPTH);
    localparam int COUNT_W    = $clog2(DEPTH + 1);

    // Operation codes carried by the action field
    localparam logic ACT_PUSH = 1'b0;
    localparam logic ACT_POP  = 1'b1;

    // Result status codes
    typedef enum logic [1:0] {
        ST_DONE      = 2'd0,
        ST_OVERFLOW  = 2'd1,
        ST_UNDERFLOW = 2'd2
    } status_t;

    // Write side of the entry and minimum-position memories
    typedef struct packed {
        logic                         entry_we;
        logic [ADDR_W-1:0]            entry_waddr;
        logic signed [DATA_WIDTH-1:0] entry_wdata;
        logic                         pos_we;
        logic [ADDR_W-1:0]            pos_waddr;
        logic [ADDR_W-1:0]            pos_wdata;
    } mem_wr_t;

    // Read side of the entry and minimum-position memories
    typedef struct packed {
        logic              entry_re;
        logic [ADDR_W-1:0] entry_raddr;
        logic              pos_re;
        logic [ADDR_W-1:0] pos_raddr;
    } mem_rd_t;

endpackage

FILE: rtl/core/mts_if.sv
interface mts_req_if;
    import mts_pkg::*;

    logic                         valid;
    logic                         ready;
    logic                         action;
    logic signed [DATA_WIDTH-1:0] value;

    modport source (output valid, output action, output value, input ready);
    modport sink (input valid, input action, input value, output ready);
endinterface

interface mts_rsp_if;
    import mts_pkg::*;

    logic                         valid;
    logic                         ready;
    status_t                      status;
    logic signed [DATA_WIDTH-1:0] min_value;
    logic                         min_valid;
    logic [COUNT_W-1:0]           fill_count;

    modport source (output valid, output status, output min_value, output min_valid,
                    output fill_count, input ready);
    modport sink (input valid, input status, input min_value, input min_valid,
                  input fill_count, output ready);
endinterface

FILE: rtl/core/mts_store.sv
module mts_store (
    input  logic                                  clk,
    input  mts_pkg::mem_wr_t                      wr,
    input  mts_pkg::mem_rd_t                      rd,
    output logic signed [mts_pkg::DATA_WIDTH-1:0] entry_rdata,
    output logic [mts_pkg::ADDR_W-1:0]            pos_rdata
);
    import mts_pkg::*;

    logic signed [DATA_WIDTH-1:0] entry_mem [DEPTH];
    logic [ADDR_W-1:0]            pos_mem [DEPTH];

    // Entry memory: one write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (wr.entry_we)
        begin
            entry_mem[wr.entry_waddr] <= wr.entry_wdata;
        end
        if (rd.entry_re)
        begin
            entry_rdata <= entry_mem[rd.entry_raddr];
        end
    end

    // Minimum-position memory: one write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (wr.pos_we)
        begin
            pos_mem[wr.pos_waddr] <= wr.pos_wdata;
        end
        if (rd.pos_re)
        begin
            pos_rdata <= pos_mem[rd.pos_raddr];
        end
    end

endmodule

FILE: rtl/core/min_tracking_stack_core.sv
// LIFO stack of signed values that reports the smallest value it holds.
// Channel req carries one item per handshake: action (push or pop) and the
// value to push. Channel rsp returns one item per request: status (done,
// overflow, underflow), the current minimum with its valid flag, and the
// fill count after the operation.
// A push, a refused push, a refused pop and a pop that empties the stack
// set the response register directly from the idle state. A pop that leaves
// entries first reads the new top entry together with the previous minimum
// position (state S_TOP); if it retires a minimum record, it then reads the
// entry at that position (state S_MIN) before the response is set.
// Pushes sustain one item per cycle while rsp.ready is held high.
// One request is in flight at a time; a new request is taken in the same
// cycle the pending response is taken. The response is held in a register
// while rsp.ready is low, and req.ready stays low until it leaves.
// Reset empties the stack at once; no clearing pass runs over the memories.
module min_tracking_stack_core (
    input  logic clk,
    input  logic rst_n,
    mts_req_if.sink   req,
    mts_rsp_if.source rsp
);
    import mts_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_TOP  = 3'b010,
        S_MIN  = 3'b100
    } state_t;

    state_t                       state_reg, state_next;
    logic [COUNT_W-1:0]           count_reg, count_next;
    logic [COUNT_W-1:0]           rec_reg, rec_next;
    logic                         drop_reg, drop_next;
    logic                         res_valid_reg, res_valid_next;
    status_t                      res_status_reg, res_status_next;
    logic signed [DATA_WIDTH-1:0] top_reg, top_next;
    logic signed [DATA_WIDTH-1:0] min_reg, min_next;

    mem_wr_t                      wr;
    mem_rd_t                      rd;
    logic signed [DATA_WIDTH-1:0] entry_rdata;
    logic [ADDR_W-1:0]            pos_rdata;

    logic               accept;
    logic               record;
    logic               drop;
    logic [COUNT_W-1:0] count_m2;
    logic [COUNT_W-1:0] rec_m2;

    mts_store u_store (
        .clk         (clk),
        .wr          (wr),
        .rd          (rd),
        .entry_rdata (entry_rdata),
        .pos_rdata   (pos_rdata)
    );

    // Take a request only when idle and the response slot is free or leaving
    assign req.ready = (state_reg == S_IDLE) && (!res_valid_reg || rsp.ready);
    assign accept    = req.valid && req.ready;

    assign count_m2 = count_reg - COUNT_W'(2);
    assign rec_m2   = rec_reg - COUNT_W'(2);
    assign record   = (rec_reg == '0) || (req.value <= min_reg);
    assign drop     = (rec_reg != '0) && (top_reg == min_reg);

    // Sequence each item through the memories
    always_comb
    begin
        state_next      = state_reg;
        count_next      = count_reg;
        rec_next        = rec_reg;
        drop_next       = drop_reg;
        res_valid_next  = res_valid_reg;
        res_status_next = res_status_reg;
        top_next        = top_reg;
        min_next        = min_reg;
        wr              = '0;
        rd              = '0;

        if (res_valid_reg && rsp.ready)
        begin
            res_valid_next = 1'b0;
        end

        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    res_status_next = ST_DONE;
                    if (req.action == ACT_PUSH)
                    begin
                        if (count_reg == COUNT_W'(DEPTH))
                        begin
                            res_status_next = ST_OVERFLOW;
                        end
                        else
                        begin
                            // Write the entry, and record its position if it is not above the current minimum
                            wr.entry_we    = 1'b1;
                            wr.entry_waddr = count_reg[ADDR_W-1:0];
                            wr.entry_wdata = req.value;
                            top_next       = req.value;
                            if (record)
                            begin
                                wr.pos_we    = 1'b1;
                                wr.pos_waddr = rec_reg[ADDR_W-1:0];
                                wr.pos_wdata = count_reg[ADDR_W-1:0];
                                rec_next     = rec_reg + COUNT_W'(1);
                                min_next     = req.value;
                            end
                            count_next = count_reg + COUNT_W'(1);
                        end
                        res_valid_next = 1'b1;
                    end
                    else
                    begin
                        if (count_reg == '0)
                        begin
                            res_status_next = ST_UNDERFLOW;
                            res_valid_next  = 1'b1;
                        end
                        else
                        begin
                            // Drop the top; retire the minimum record if it was the minimum
                            count_next = count_reg - COUNT_W'(1);
                            drop_next  = drop;
                            if (drop)
                            begin
                                rec_next = rec_reg - COUNT_W'(1);
                            end
                            if (count_reg == COUNT_W'(1))
                            begin
                                res_valid_next = 1'b1;
                            end
                            else
                            begin
                                // Fetch the new top and the previous minimum position
                                rd.entry_re    = 1'b1;
                                rd.entry_raddr = count_m2[ADDR_W-1:0];
                                rd.pos_re      = 1'b1;
                                rd.pos_raddr   = rec_m2[ADDR_W-1:0];
                                state_next     = S_TOP;
                            end
                        end
                    end
                end
            end
            S_TOP:
            begin
                top_next = entry_rdata;
                if (drop_reg && (rec_reg != '0))
                begin
                    // Fetch the value the previous minimum record points at
                    rd.entry_re    = 1'b1;
                    rd.entry_raddr = pos_rdata;
                    state_next     = S_MIN;
                end
                else
                begin
                    res_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            S_MIN:
            begin
                min_next       = entry_rdata;
                res_valid_next = 1'b1;
                state_next     = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            count_reg      <= '0;
            rec_reg        <= '0;
            drop_reg       <= 1'b0;
            res_valid_reg  <= 1'b0;
            res_status_reg <= ST_DONE;
        end
        else
        begin
            state_reg      <= state_next;
            count_reg      <= count_next;
            rec_reg        <= rec_next;
            drop_reg       <= drop_next;
            res_valid_reg  <= res_valid_next;
            res_status_reg <= res_status_next;
        end
    end

    // Cached top entry and current minimum
    always_ff @(posedge clk)
    begin
        top_reg <= top_next;
        min_reg <= min_next;
    end

    // Drive the response from the held state
    assign rsp.valid      = res_valid_reg;
    assign rsp.status     = res_status_reg;
    assign rsp.min_valid  = (count_reg != '0);
    assign rsp.min_value  = (count_reg != '0) ? min_reg : '0;
    assign rsp.fill_count = count_reg;

`ifndef NO_ASSERTIONS
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg <= COUNT_W'(DEPTH)) && (rec_reg <= count_reg))
        else $error("stack or record count out of range");

    a_rec_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg != '0) |-> (rec_reg != '0))
        else $error("entries held without a minimum record");

    a_busy_no_accept: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != S_IDLE) |-> (!req.ready && !res_valid_reg))
        else $error("request or response while a pop is in progress");

    a_overflow_full: assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid_reg && (res_status_reg == ST_OVERFLOW)) |-> (count_reg == COUNT_W'(DEPTH)))
        else $error("overflow reported on a stack that is not full");
`endif

endmodule
